@@ rtl/amd_pkg.sv @@
// Shared types and constants for the aggregate message deframer.
`timescale 1ns / 1ps

package amd_pkg;

    // Header layout: byte 0 type, 1..3 size, 4..6 timestamp, 7 extended, 8..10 stream id
    localparam int unsigned HDR_LAST_IDX = 10;
    localparam int unsigned SIZE_LAST_IDX = 3;
    localparam int unsigned TS_LAST_IDX = 6;
    localparam int unsigned EXT_TS_IDX = 7;
    localparam int unsigned BACKPTR_LAST_IDX = 3;

    localparam logic [7:0] TYPE_AUDIO = 8'd8;
    localparam logic [7:0] TYPE_VIDEO = 8'd9;

    // Result queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_BACKPTR = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_HEADER  = 2'd1,
        ERR_PAYLOAD = 2'd2,
        ERR_BACKPTR = 2'd3
    } err_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  msg_type;
        logic [23:0] payload_len;
        logic [30:0] raw_timestamp;
        logic [31:0] rebased_timestamp;
        logic [23:0] sub_stream_id;
        logic [7:0]  payload_byte;
        logic        last_of_sub;
        err_t        error_code;
    } result_t;

    // Write request into the result queue: up to two results per input transaction
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

endpackage

@@ rtl/amd_rfifo.sv @@
// Small result queue: takes up to two results per cycle, hands out one.
`timescale 1ns / 1ps

module amd_rfifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  amd_pkg::push_t   push,
    input  amd_pkg::result_t wr_first,
    input  amd_pkg::result_t wr_second,
    input  logic             pop,
    output amd_pkg::result_t head,
    output logic             not_empty,
    output logic             has_room
);
    import amd_pkg::*;

    result_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_CW-1:0]   count_next;
    logic [FIFO_AW-1:0]   wr_ptr_plus1;
    logic [FIFO_CW-1:0]   push_n;

    assign wr_ptr_plus1 = FIFO_AW'(wr_ptr_reg + 1'b1);
    assign push_n = FIFO_CW'({1'b0, push.first}) + FIFO_CW'({1'b0, push.second});

    assign head = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign has_room = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push.first)
        begin
            wr_ptr_next = push.second ? FIFO_AW'(wr_ptr_reg + 2'd2) : wr_ptr_plus1;
        end
        if (pop)
        begin
            rd_ptr_next = FIFO_AW'(rd_ptr_reg + 1'b1);
        end
        count_next = FIFO_CW'(count_reg + push_n - FIFO_CW'({1'b0, pop}));
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            mem[wr_ptr_reg] <= wr_first;
        end
        if (push.second)
        begin
            mem[wr_ptr_plus1] <= wr_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue count beyond depth");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.first |-> has_room)
        else $error("result written without room for two");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> push.first)
        else $error("second result written alone");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("result taken from empty queue");
`endif

endmodule

@@ rtl/aggregate_message_deframer_core.sv @@
// Aggregate message deframer: top level, byte parser and result queue.
`timescale 1ns / 1ps

// Splits the payload of an aggregate message, presented one byte per input
// transaction, into sub-messages (11-byte header, payload, 4-byte back pointer,
// which is skipped). Audio (type 8) and video (type 9) sub-messages produce a
// header result followed by one result per payload byte; other types are
// swallowed. Timestamps are masked to 31 bits and rebased as
// parent + (timestamp - first timestamp of the message), modulo 2^32. An end
// mark inside a header, payload or back pointer adds an error result, and bytes
// after an end mark are dropped until the next start mark. Rate: one byte per
// clock while the result queue has room. Each byte is parsed in the cycle it
// is accepted and its results are written to a four-entry result queue; the
// master side is driven from the registered head of that queue. A byte makes
// at most two results (two only on an end mark with an error); s_axis_tready
// is held low whenever the queue has fewer than two free entries, so the rate
// is set by the master side draining one result per cycle.
module aggregate_message_deframer_core
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // [7:0] data_byte, [39:8] parent_timestamp
    input  logic         s_axis_tuser,   // [0] msg_start
    input  logic         s_axis_tlast,   // msg_end

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,   // [7:0] sub-message type, [31:8] payload size,
                                         // [62:32] raw_timestamp,
                                         // [94:63] rebased_timestamp,
                                         // [118:95] sub_stream_id,
                                         // [126:119] payload_byte,
                                         // [128:127] error_code, [135:129] zero
    output logic [1:0]   m_axis_tuser,   // [1:0] kind
    output logic         m_axis_tlast    // last_of_sub
);
    import amd_pkg::*;

    // Parser state
    phase_t      phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;          // byte index in header / back pointer
    logic [23:0] rem_reg, rem_next;          // payload bytes still to come
    logic [7:0]  type_reg, type_next;
    logic [23:0] size_reg, size_next;
    logic [30:0] ts_reg, ts_next;
    logic [23:0] stream_reg, stream_next;
    logic [30:0] base_reg, base_next;        // first timestamp in this message
    logic        base_taken_reg, base_taken_next;
    logic [31:0] parent_reg, parent_next;
    logic        fwd_reg, fwd_next;          // current sub-message is audio/video
    logic        drop_reg, drop_next;        // between end mark and next start mark

    logic        accept;
    logic [7:0]  in_byte;
    logic [31:0] in_parent;
    logic [3:0]  hdr_idx;
    logic [31:0] rebased;

    logic        emit_main;
    logic        emit_err;
    kind_t       main_kind;
    logic        main_last;
    logic [7:0]  main_byte;
    err_t        err_code;
    result_t     main_res;
    result_t     err_res;

    push_t       push;
    result_t     head;
    logic        q_not_empty;
    logic        q_has_room;

    assign in_byte   = s_axis_tdata[7:0];
    assign in_parent = s_axis_tdata[39:8];
    assign accept    = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = q_has_room;

    // Timestamp, base and parent never change on a byte that emits a header or
    // payload result, so the registered values are the ones to report.
    assign rebased = parent_reg + {1'b0, ts_reg} - {1'b0, base_reg};

    //--------------------------------------------------------------------
    // Byte parser
    //--------------------------------------------------------------------
    always_comb
    begin
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        rem_next        = rem_reg;
        type_next       = type_reg;
        size_next       = size_reg;
        ts_next         = ts_reg;
        stream_next     = stream_reg;
        base_next       = base_reg;
        base_taken_next = base_taken_reg;
        parent_next     = parent_reg;
        fwd_next        = fwd_reg;
        drop_next       = drop_reg;
        hdr_idx         = cnt_reg;
        emit_main       = 1'b0;
        emit_err        = 1'b0;
        main_kind       = KIND_HEADER;
        main_last       = 1'b0;
        main_byte       = '0;
        err_code        = ERR_NONE;

        if (accept)
        begin
            // Start mark: restart at a header, new parent time, new base
            if (s_axis_tuser)
            begin
                phase_next      = PH_HEADER;
                cnt_next        = '0;
                rem_next        = '0;
                base_taken_next = 1'b0;
                parent_next     = in_parent;
                fwd_next        = 1'b0;
                drop_next       = 1'b0;
            end

            if (!drop_next)
            begin
                unique case (phase_next)
                    PH_HEADER:
                    begin
                        hdr_idx = cnt_next;
                        priority if (hdr_idx == 4'd0)
                        begin
                            type_next   = in_byte;
                            size_next   = '0;
                            ts_next     = '0;
                            stream_next = '0;
                        end
                        else if (hdr_idx <= 4'(SIZE_LAST_IDX))
                        begin
                            size_next = {size_next[15:0], in_byte};
                        end
                        else if (hdr_idx <= 4'(TS_LAST_IDX))
                        begin
                            ts_next = {7'd0, ts_next[15:0], in_byte};
                        end
                        else if (hdr_idx == 4'(EXT_TS_IDX))
                        begin
                            // only the low 7 bits of the extended byte survive the mask
                            ts_next = {in_byte[6:0], ts_next[23:0]};
                            if (!base_taken_next)
                            begin
                                base_next       = {in_byte[6:0], ts_next[23:0]};
                                base_taken_next = 1'b1;
                            end
                        end
                        else
                        begin
                            stream_next = {stream_next[15:0], in_byte};
                        end

                        if (hdr_idx == 4'(HDR_LAST_IDX))
                        begin
                            fwd_next  = (type_next == TYPE_AUDIO) || (type_next == TYPE_VIDEO);
                            emit_main = fwd_next;
                            main_kind = KIND_HEADER;
                            main_last = (size_next == '0);
                            cnt_next  = '0;
                            if (size_next != '0)
                            begin
                                rem_next   = size_next;
                                phase_next = PH_PAYLOAD;
                            end
                            else
                            begin
                                phase_next = PH_BACKPTR;
                            end
                        end
                        else
                        begin
                            cnt_next = 4'(hdr_idx + 1'b1);
                        end
                    end

                    PH_PAYLOAD:
                    begin
                        emit_main = fwd_next;
                        main_kind = KIND_PAYLOAD;
                        main_last = (rem_next == 24'd1);
                        main_byte = in_byte;
                        rem_next  = 24'(rem_next - 1'b1);
                        if (rem_next == '0)
                        begin
                            phase_next = PH_BACKPTR;
                            cnt_next   = '0;
                        end
                    end

                    PH_BACKPTR:
                    begin
                        // back pointer is skipped, not checked
                        if (cnt_next == 4'(BACKPTR_LAST_IDX))
                        begin
                            phase_next = PH_HEADER;
                            cnt_next   = '0;
                        end
                        else
                        begin
                            cnt_next = 4'(cnt_next + 1'b1);
                        end
                    end

                    default:
                    begin
                        phase_next = PH_HEADER;
                        cnt_next   = '0;
                    end
                endcase

                // End mark: report anything left unfinished, then drop until next start
                if (s_axis_tlast)
                begin
                    unique case (phase_next)
                        PH_HEADER:  err_code = (cnt_next != '0) ? ERR_HEADER : ERR_NONE;
                        PH_PAYLOAD: err_code = ERR_PAYLOAD;
                        default:    err_code = ERR_BACKPTR;
                    endcase
                    emit_err        = (err_code != ERR_NONE);
                    phase_next      = PH_HEADER;
                    cnt_next        = '0;
                    rem_next        = '0;
                    fwd_next        = 1'b0;
                    base_taken_next = 1'b0;
                    drop_next       = 1'b1;
                end
            end
        end
    end

    // Header or payload result with the header fields of the current sub-message, and the error result
    always_comb
    begin
        main_res.kind              = main_kind;
        main_res.msg_type          = type_next;
        main_res.payload_len       = size_next;
        main_res.raw_timestamp     = ts_reg;
        main_res.rebased_timestamp = rebased;
        main_res.sub_stream_id     = stream_next;
        main_res.payload_byte      = main_byte;
        main_res.last_of_sub       = main_last;
        main_res.error_code        = ERR_NONE;

        err_res                    = '0;
        err_res.kind               = KIND_ERROR;
        err_res.error_code         = err_code;
    end

    assign push.first  = emit_main | emit_err;
    assign push.second = emit_main & emit_err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            cnt_reg        <= '0;
            rem_reg        <= '0;
            type_reg       <= '0;
            size_reg       <= '0;
            ts_reg         <= '0;
            stream_reg     <= '0;
            base_reg       <= '0;
            base_taken_reg <= 1'b0;
            parent_reg     <= '0;
            fwd_reg        <= 1'b0;
            drop_reg       <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            rem_reg        <= rem_next;
            type_reg       <= type_next;
            size_reg       <= size_next;
            ts_reg         <= ts_next;
            stream_reg     <= stream_next;
            base_reg       <= base_next;
            base_taken_reg <= base_taken_next;
            parent_reg     <= parent_next;
            fwd_reg        <= fwd_next;
            drop_reg       <= drop_next;
        end
    end

    //--------------------------------------------------------------------
    // Result queue and master side
    //--------------------------------------------------------------------
    amd_rfifo u_rfifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_first  (emit_main ? main_res : err_res),
        .wr_second (err_res),
        .pop       (m_axis_tvalid & m_axis_tready),
        .head      (head),
        .not_empty (q_not_empty),
        .has_room  (q_has_room)
    );

    assign m_axis_tvalid = q_not_empty;
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last_of_sub;
    assign m_axis_tdata  = {7'd0, head.error_code, head.payload_byte, head.sub_stream_id,
                            head.rebased_timestamp, head.raw_timestamp,
                            head.payload_len, head.msg_type};

`ifndef ASSERT_OFF
    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (rem_reg != '0))
        else $error("payload phase with nothing remaining");

    a_hdr_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER) |-> (cnt_reg <= 4'(HDR_LAST_IDX)))
        else $error("header byte index out of range");

    a_bp_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BACKPTR) |-> (cnt_reg <= 4'(BACKPTR_LAST_IDX)))
        else $error("back pointer byte index out of range");

    a_drop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg |-> (phase_reg == PH_HEADER) && (cnt_reg == '0) && !fwd_reg)
        else $error("parser not idle while dropping");
`endif

endmodule
